>>> hdl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define CHK_IMPLY(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> hdl/mfek_pkg.sv
// shared types and constants of the max flow core
`default_nettype none
package mfek_pkg;
   localparam int MaxNodes = 64;
   localparam int CapBits = 16;
   localparam int NodeBits = $clog2(MaxNodes);
   localparam int CntBits = NodeBits + 1;
   localparam int ResBits = CapBits + 1;
   localparam int FlowBits = 22;
   localparam int AddrBits = 2 * NodeBits;
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_RUN = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;
   localparam logic [1:0] REG_SOURCE = 2'd0;
   localparam logic [1:0] REG_SINK = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] from_node;
      logic [5:0] to_node;
      logic [15:0] edge_capacity;
   } req_type;

   typedef struct packed {
      logic [21:0] result_value;
      logic [1:0] result_kind;
   } rsp_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic we;
      logic [AddrBits-1:0] addr;
      logic [ResBits-1:0] wdata;
   } mem_req_type;
endpackage
`default_nettype wire

>>> hdl/mfek_ram.sv
// single port residual matrix memory with registered read and epoch clear
`default_nettype none
module mfek_ram (
   input wire logic clock,
   input wire logic reset,
   input wire logic clear,
   input wire mfek_pkg::mem_req_type mreq,
   output logic [mfek_pkg::ResBits-1:0] rdata,
   output logic sweeping
);
   localparam int Depth = mfek_pkg::MaxNodes * mfek_pkg::MaxNodes;
   logic [mfek_pkg::ResBits+7:0] mem [Depth];
   logic [7:0] epoch_ff;
   logic [mfek_pkg::ResBits+7:0] q_ff;
   logic [7:0] qepoch_ff;
   logic wrap_ff;
   logic [mfek_pkg::AddrBits:0] sweep_ff;

   // epoch mark per entry: stale epoch reads as zero; epoch wrap forces a sweep
   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.addr] <= {epoch_ff, mreq.wdata};
      end else if (wrap_ff) begin
         mem[sweep_ff[mfek_pkg::AddrBits-1:0]] <= '0;
      end
      q_ff <= mem[mreq.addr];
      qepoch_ff <= epoch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 8'd1;
         wrap_ff <= 1'b1;
         sweep_ff <= '0;
      end else if (wrap_ff) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (sweep_ff == (mfek_pkg::AddrBits+1)'(Depth - 1)) begin
            wrap_ff <= 1'b0;
         end
      end else if (clear) begin
         if (epoch_ff == 8'hff) begin
            epoch_ff <= 8'd1;
            wrap_ff <= 1'b1;
            sweep_ff <= '0;
         end else begin
            epoch_ff <= epoch_ff + 8'd1;
         end
      end
   end

   assign sweeping = wrap_ff;
   assign rdata = (q_ff[mfek_pkg::ResBits+7:mfek_pkg::ResBits] == qepoch_ff)
         ? q_ff[mfek_pkg::ResBits-1:0] : '0;
endmodule
`default_nettype wire

>>> hdl/mfek_seq.sv
// sequencer: item decode, breadth-first search, bottleneck and augment passes
`default_nettype none
module mfek_seq (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire mfek_pkg::req_type item,
   input wire logic [5:0] src,
   input wire logic [5:0] dst,
   input wire logic [6:0] ncount,
   input wire logic [mfek_pkg::ResBits-1:0] rdata,
   output mfek_pkg::mem_req_type mreq,
   output logic clear,
   output logic busy,
   output logic done,
   output logic [21:0] value
);
   localparam int NB = mfek_pkg::NodeBits;
   localparam int CB = mfek_pkg::CntBits;
   localparam int RB = mfek_pkg::ResBits;
   localparam int MN = mfek_pkg::MaxNodes;
   localparam logic [3:0] S_IDLE = 4'd0, S_RDW = 4'd1, S_RDD = 4'd2, S_BINIT = 4'd3,
      S_POP = 4'd4, S_SCAN = 4'd5, S_NK = 4'd6, S_NKW = 4'd7, S_AF = 4'd8,
      S_AFW = 4'd9, S_AB = 4'd10, S_ABW = 4'd11, S_DONE = 4'd12, S_QRD = 4'd13,
      S_NKA = 4'd14, S_AFA = 4'd15;
   logic [3:0] st_ff, st_in;
   logic [NB-1:0] parent [mfek_pkg::MaxNodes];
   logic [NB-1:0] queue [mfek_pkg::MaxNodes];
   logic [mfek_pkg::MaxNodes-1:0] seen_ff;
   logic [CB-1:0] head_ff, tail_ff, v_ff, n_ff;
   logic [NB-1:0] cur_ff, walk_ff, prevq_ff, qout_ff;
   logic [RB-1:0] neck_ff;
   logic [21:0] flow_ff;
   logic [1:0] kind_ff;
   logic vld_ff;
   logic [NB-1:0] pw_ff;
   logic [22:0] fsum;
   logic [RB:0] bsum;

   assign fsum = {1'b0, flow_ff} + 23'(neck_ff);
   assign bsum = {1'b0, rdata} + {1'b0, neck_ff};

   // parent of the node on the walk, registered: valid in the cycle after walk_ff settles
   always_ff @(posedge clock) begin
      pw_ff <= parent[walk_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         flow_ff <= '0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            S_IDLE: if (start) begin
               kind_ff <= item.kind;
               flow_ff <= '0;
               n_ff <= (ncount > 7'(mfek_pkg::MaxNodes)) ? CB'(mfek_pkg::MaxNodes)
                     : CB'(ncount);
            end
            S_BINIT: begin
               seen_ff <= MN'(1) << src;
               parent[src] <= src;
               queue[0] <= src;
               head_ff <= '0;
               tail_ff <= CB'(1);
            end
            S_POP: begin
               qout_ff <= queue[head_ff[NB-1:0]];
            end
            S_QRD: begin
               cur_ff <= qout_ff;
               head_ff <= head_ff + 1'b1;
               v_ff <= '0;
            end
            S_SCAN: begin
               // rdata is the entry for v_ff-1 requested last cycle
               if (vld_ff && !seen_ff[prevq_ff] && rdata != '0) begin
                  seen_ff[prevq_ff] <= 1'b1;
                  parent[prevq_ff] <= cur_ff;
                  if (prevq_ff != dst && tail_ff < CB'(mfek_pkg::MaxNodes)) begin
                     queue[tail_ff[NB-1:0]] <= prevq_ff;
                     tail_ff <= tail_ff + 1'b1;
                  end
               end
               if (v_ff < n_ff) v_ff <= v_ff + 1'b1;
               walk_ff <= dst;
               neck_ff <= '1;
            end
            S_NKW: begin
               if (rdata < neck_ff) neck_ff <= rdata;
               // augment pass walks the path again from the sink
               walk_ff <= (pw_ff == src) ? dst : pw_ff;
            end
            S_AF: ;
            S_AFW: ;
            S_ABW: begin
               walk_ff <= pw_ff;
               if (pw_ff == src) flow_ff <= fsum[22] ? '1 : fsum[21:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= (st_ff == S_SCAN) && (v_ff < n_ff);
         prevq_ff <= v_ff[NB-1:0];
      end
   end

   always_comb begin
      logic hit;
      st_in = st_ff;
      mreq = '0;
      clear = 1'b0;
      hit = vld_ff && !seen_ff[prevq_ff] && rdata != '0 && prevq_ff == dst;
      unique case (st_ff)
         S_IDLE: if (start) begin
            unique case (item.kind)
               mfek_pkg::KIND_WRITE: begin
                  mreq.we = 1'b1;
                  mreq.addr = {item.from_node, item.to_node};
                  mreq.wdata = RB'(item.edge_capacity);
                  st_in = S_DONE;
               end
               mfek_pkg::KIND_READ: begin
                  mreq.addr = {item.from_node, item.to_node};
                  st_in = S_RDW;
               end
               mfek_pkg::KIND_CLEAR: begin
                  clear = 1'b1;
                  st_in = S_DONE;
               end
               default: st_in = (src >= ncount[5:0] && ncount < 7'd64) || src == dst ||
                     (dst >= ncount[5:0] && ncount < 7'd64) || ncount == '0
                     ? S_DONE : S_BINIT;
            endcase
         end
         S_RDW: st_in = S_RDD;
         S_RDD: st_in = S_DONE;
         S_BINIT: st_in = S_POP;
         S_POP: st_in = (head_ff < tail_ff) ? S_QRD : S_DONE;
         S_QRD: st_in = S_SCAN;
         S_SCAN: begin
            mreq.addr = {cur_ff, v_ff[NB-1:0]};
            if (hit) st_in = S_NK;
            else if (v_ff >= n_ff && !vld_ff) st_in = S_POP;
         end
         S_NK: st_in = S_NKA;
         S_NKA: begin
            mreq.addr = {pw_ff, walk_ff};
            st_in = S_NKW;
         end
         S_NKW: st_in = (pw_ff == src) ? S_AF : S_NK;
         S_AF: st_in = S_AFA;
         S_AFA: begin
            mreq.addr = {pw_ff, walk_ff};
            st_in = S_AFW;
         end
         S_AFW: begin
            // forward entry minus bottleneck, then read the reverse entry
            mreq.we = 1'b1;
            mreq.addr = {pw_ff, walk_ff};
            mreq.wdata = rdata - neck_ff;
            st_in = S_AB;
         end
         S_AB: begin
            mreq.addr = {walk_ff, pw_ff};
            st_in = S_ABW;
         end
         S_ABW: begin
            mreq.we = 1'b1;
            mreq.addr = {walk_ff, pw_ff};
            mreq.wdata = bsum[RB] ? '1 : bsum[RB-1:0];
            st_in = (pw_ff == src) ? S_BINIT : S_AF;
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   logic [RB-1:0] rd_ff;
   always_ff @(posedge clock) begin
      if (st_ff == S_RDW) rd_ff <= rdata;
   end

   assign busy = st_ff != S_IDLE;
   assign done = st_ff == S_DONE;
   always_comb begin
      case (kind_ff)
         mfek_pkg::KIND_RUN: value = flow_ff;
         mfek_pkg::KIND_READ: value = 22'(rd_ff);
         default: value = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> hdl/max_flow_edmonds_karp_core.sv
// top level: config registers, output register and handshakes
// rsp_valid is registered from done; a read passes S_RDW and S_RDD, write and clear do not
// run: scans each dequeued node's row; walks each path for its bottleneck, then augments it
// one item in flight; the next is accepted only after the result has transferred
// reset: synchronous; all 4096 matrix entries are swept after reset and after
// every 255th clear, and no item is accepted meanwhile
`default_nettype none
`include "assert_macros.svh"
module max_flow_edmonds_karp_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire mfek_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output mfek_pkg::rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [3:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [5:0] src_ff, dst_ff;
   logic [6:0] cnt_ff;
   logic busy, done, clear, start, sweeping, out_ff;
   logic [21:0] value;
   logic [mfek_pkg::ResBits-1:0] rdata;
   mfek_pkg::mem_req_type mreq;
   mfek_pkg::rsp_type rsp_ff;
   logic [1:0] kind_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= '0;
         dst_ff <= 6'd1;
         cnt_ff <= 7'd64;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            mfek_pkg::REG_SOURCE: src_ff <= csr_pwdata[5:0];
            mfek_pkg::REG_SINK: dst_ff <= csr_pwdata[5:0];
            mfek_pkg::REG_COUNT: cnt_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[3:2])
         mfek_pkg::REG_SOURCE: csr_prdata = {26'd0, src_ff};
         mfek_pkg::REG_SINK: csr_prdata = {26'd0, dst_ff};
         mfek_pkg::REG_COUNT: csr_prdata = {25'd0, cnt_ff};
         default: csr_prdata = '0;
      endcase
   end

   // hold off transfers while busy, while a result waits or while the memory sweeps
   assign req_stall = busy || out_ff || sweeping;
   assign start = req_valid && !req_stall;

   mfek_seq u_seq (
      .clock, .reset, .start, .item(req_data), .src(src_ff), .dst(dst_ff),
      .ncount(cnt_ff), .rdata, .mreq, .clear, .busy, .done, .value
   );
   mfek_ram u_ram (.clock, .reset, .clear, .mreq, .rdata, .sweeping);

   always_ff @(posedge clock) begin
      if (start) kind_ff <= req_data.kind;
      if (done) rsp_ff <= '{result_value: value, result_kind: kind_ff};
   end
   always_ff @(posedge clock) begin
      if (reset) out_ff <= 1'b0;
      else if (done) out_ff <= 1'b1;
      else if (!rsp_stall) out_ff <= 1'b0;
   end
   assign rsp_valid = out_ff;
   assign rsp_data = rsp_ff;

   `CHK_IMPLY(a_no_start_busy, clock, reset, start, !busy && !out_ff)
   `CHK_NEXT(a_done_valid, clock, reset, done, rsp_valid)
   `CHK_IMPLY(a_done_free, clock, reset, done, !out_ff)
endmodule
`default_nettype wire
